### rtl/tccg_pkg.sv
`timescale 1ns / 1ps

package tccg_pkg;

  localparam int FONT_COUNT_DEF   = 4;
  localparam int TEXT_COLUMNS_DEF = 32;
  localparam int TEXT_ROWS_DEF    = 24;

  // request codes on the input channel
  localparam logic [1:0] FUNC_FONT_WRITE = 2'd0;
  localparam logic [1:0] FUNC_CELL_CHECK = 2'd1;
  localparam logic [1:0] FUNC_FRAME_END  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_COLOR_MODE    = 2'd0;
  localparam logic [1:0] CFG_NEGATIVE_MODE = 2'd1;
  localparam logic [1:0] CFG_FONT_SELECT   = 2'd2;

  localparam logic [7:0] SHADOW_CHAR_RESET = 8'h00;
  localparam logic [7:0] SHADOW_ATTR_RESET = 8'h0F;
  localparam logic [3:0] COLOR_MAX         = 4'hF;
  localparam logic [2:0] ROW_LAST          = 3'd7;

  typedef struct packed {
    logic       color_mode;
    logic       negative_mode;
    logic [1:0] font_select;
  } cfg_t;

  typedef struct packed {
    logic [9:0] cell_idx;
    logic [2:0] row;
    logic [7:0] attr;
  } row_meta_t;

endpackage

### rtl/text_cell_character_generator_core.sv
`timescale 1ns / 1ps
// Text-mode character generator, 8x8 glyphs over a TEXT_COLUMNS x TEXT_ROWS screen.
// Input channel (in_valid/in_stall): font byte writes, cell checks and frame ends.
// Output channel (out_valid/out_stall): one glyph row of eight colour indices per
// transfer, eight transfers per redrawn cell, last_row set on row 7.
// Config channel (cfg_valid/cfg_ready): always ready; index 0 color_mode,
// 1 negative_mode, 2 font_select; write only while the block is idle.
// A cell check that redraws holds the row sequencer while its eight rows are read,
// since the glyph memory has one read port and gives one row per cycle while the
// output does not stall; frame ends and unchanged or off-screen cells skip it.
// A font write behind a redraw waits until that cell's last row has been read.
// Rows pass the check stage, row sequencer, glyph read stage and output register.
// Reset: the shadow store is swept to char 0 / attr 15, one cell per cycle,
// all CELL_COUNT cells (768 by default) with in_stall high; config writes still go.
// Glyph memory content is undefined until written.
// When the receiver stalls, the output row holds, one more row waits in the glyph
// read stage, the sequencer stalls, and the input stalls on a redraw or font write.

module text_cell_character_generator_core import tccg_pkg::*; #(
  parameter int FONT_COUNT   = FONT_COUNT_DEF,
  parameter int TEXT_COLUMNS = TEXT_COLUMNS_DEF,
  parameter int TEXT_ROWS    = TEXT_ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] func,
  input  logic [9:0] cell_req,
  input  logic [7:0] char_code,
  input  logic [7:0] attribute,
  input  logic [1:0] font_index,
  input  logic [2:0] font_row,
  input  logic [7:0] font_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [9:0] out_cell,
  output logic [2:0] pixel_row,
  output logic [3:0] pixel_0,
  output logic [3:0] pixel_1,
  output logic [3:0] pixel_2,
  output logic [3:0] pixel_3,
  output logic [3:0] pixel_4,
  output logic [3:0] pixel_5,
  output logic [3:0] pixel_6,
  output logic [3:0] pixel_7,
  output logic       last_row,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [1:0] cfg_data
);

  localparam int CELL_COUNT  = TEXT_COLUMNS * TEXT_ROWS;
  localparam int CELL_W      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int FONT_W      = (FONT_COUNT > 1) ? $clog2(FONT_COUNT) : 1;
  localparam int GLYPH_DEPTH = FONT_COUNT * 2048;
  localparam int GADDR_W     = $clog2(GLYPH_DEPTH);

  function automatic logic [FONT_W-1:0] font_wrap(input logic [1:0] f);
    logic [8:0] v;
    v = 9'(f);
    for (int i = 0; i < 3; i++) begin
      if (v >= 9'(FONT_COUNT)) begin
        v = v - 9'(FONT_COUNT);
      end
    end
    return FONT_W'(v);
  endfunction

  function automatic logic [GADDR_W-1:0] glyph_addr(input logic [1:0] f, input logic [7:0] code,
                                                    input logic [2:0] row);
    return GADDR_W'({font_wrap(f), code, row});
  endfunction

  // configuration
  cfg_t cfg;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COLOR_MODE:    cfg.color_mode    <= cfg_data[0];
        CFG_NEGATIVE_MODE: cfg.negative_mode <= cfg_data[0];
        CFG_FONT_SELECT:   cfg.font_select   <= cfg_data;
        default: ;
      endcase
    end
  end

  // check stage
  logic              in_fire;
  logic              in_range;
  logic              clearing;
  logic              s1_valid;
  logic [1:0]        s1_func;
  logic              s1_in_range;
  logic [CELL_W-1:0] s1_addr;
  logic [9:0]        s1_cell;
  logic [7:0]        s1_code;
  logic [7:0]        s1_attr;
  logic [1:0]        s1_fidx;
  logic [2:0]        s1_frow;
  logic [7:0]        s1_fbyte;
  logic [1:0]        drawn_font;
  logic              fwd;
  logic [15:0]       fwd_data;
  logic [15:0]       shadow_q;
  logic [15:0]       shadow_cur;
  logic              s1_draw;
  logic              s1_font_wr;
  logic              s1_advance;
  logic              shadow_we;

  // row sequencer and glyph read stage
  logic              seq_busy;
  logic [2:0]        seq_row;
  logic [9:0]        seq_cell;
  logic [7:0]        seq_code;
  logic [7:0]        seq_attr;
  logic              seq_issue;
  logic              seq_free;
  logic              seq_load;
  logic              g_valid;
  row_meta_t         g_meta;
  logic [7:0]        glyph_q;
  logic              po_ready;
  logic              g_moves;
  logic [7:0]        glyph_mem [GLYPH_DEPTH];

  assign in_range = 32'(cell_req) < CELL_COUNT;
  assign in_fire  = in_valid && !in_stall;
  assign in_stall = clearing || (s1_valid && !s1_advance);

  assign shadow_cur = fwd ? fwd_data : shadow_q;
  assign s1_draw    = (s1_func == FUNC_CELL_CHECK) && s1_in_range &&
                      ((shadow_cur != {s1_code, s1_attr}) || (drawn_font != cfg.font_select));
  assign s1_font_wr = (s1_func == FUNC_FONT_WRITE);
  assign s1_advance = s1_valid && (!(s1_draw || s1_font_wr) || seq_free);
  assign shadow_we  = s1_advance && s1_draw;
  assign seq_load   = shadow_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd      <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
        // the cell being written now is read before the write lands
        fwd      <= shadow_we && (s1_addr == CELL_W'(cell_req));
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func     <= func;
      s1_in_range <= in_range;
      s1_addr     <= CELL_W'(cell_req);
      s1_cell     <= cell_req;
      s1_code     <= char_code;
      s1_attr     <= attribute;
      s1_fidx     <= font_index;
      s1_frow     <= font_row;
      s1_fbyte    <= font_byte;
      fwd_data    <= {s1_code, s1_attr};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drawn_font <= '0;
    end else if (s1_advance && s1_func == FUNC_FRAME_END) begin
      drawn_font <= cfg.font_select;
    end
  end

  tccg_shadow_ram #(
    .CELL_COUNT (CELL_COUNT),
    .CELL_W     (CELL_W)
  ) u_shadow (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (in_fire && in_range),
    .rd_addr  (CELL_W'(cell_req)),
    .rd_data  (shadow_q),
    .wr_en    (shadow_we),
    .wr_addr  (s1_addr),
    .wr_data  ({s1_code, s1_attr}),
    .clearing (clearing)
  );

  // issue a glyph read only when the read stage is free next cycle
  assign g_moves   = g_valid && po_ready;
  assign seq_issue = seq_busy && (!g_valid || g_moves);
  assign seq_free  = !seq_busy || (seq_issue && seq_row == ROW_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_busy <= 1'b0;
      g_valid  <= 1'b0;
    end else begin
      if (seq_load) begin
        seq_busy <= 1'b1;
      end else if (seq_issue && seq_row == ROW_LAST) begin
        seq_busy <= 1'b0;
      end
      if (seq_issue) begin
        g_valid <= 1'b1;
      end else if (g_moves) begin
        g_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (seq_load) begin
      seq_row  <= '0;
      seq_cell <= s1_cell;
      seq_code <= s1_code;
      seq_attr <= s1_attr;
    end else if (seq_issue) begin
      seq_row <= seq_row + 1'b1;
    end
    if (seq_issue) begin
      g_meta <= '{cell_idx: seq_cell, row: seq_row, attr: seq_attr};
    end
  end

  always_ff @(posedge clk) begin
    if (seq_issue) begin
      glyph_q <= glyph_mem[glyph_addr(cfg.font_select, seq_code, seq_row)];
    end
    if (s1_advance && s1_font_wr) begin
      glyph_mem[glyph_addr(s1_fidx, s1_code, s1_frow)] <= s1_fbyte;
    end
  end

  tccg_pixel_out u_pixel_out (
    .clk       (clk),
    .rst       (rst),
    .row_valid (g_valid),
    .row_ready (po_ready),
    .glyph     (glyph_q),
    .meta      (g_meta),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_cell  (out_cell),
    .pixel_row (pixel_row),
    .pixel_0   (pixel_0),
    .pixel_1   (pixel_1),
    .pixel_2   (pixel_2),
    .pixel_3   (pixel_3),
    .pixel_4   (pixel_4),
    .pixel_5   (pixel_5),
    .pixel_6   (pixel_6),
    .pixel_7   (pixel_7),
    .last_row  (last_row)
  );

  a_no_shadow_wr_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !shadow_we)
    else $error("shadow write during clearing pass");

  a_no_issue_over_held_row: assert property (@(posedge clk) disable iff (rst)
    (g_valid && !g_moves) |-> !seq_issue)
    else $error("glyph read would overwrite a held row");

  a_seq_ends_after_last_row: assert property (@(posedge clk) disable iff (rst)
    (seq_issue && seq_row == ROW_LAST && !seq_load) |=> !seq_busy)
    else $error("sequencer ran past the last row");

  a_font_wr_after_draw: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_font_wr) |-> seq_free)
    else $error("font write overtook a pending glyph read");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    seq_load |-> seq_free)
    else $error("cell loaded while sequencer still drawing");

endmodule

### rtl/tccg_shadow_ram.sv
`timescale 1ns / 1ps

module tccg_shadow_ram import tccg_pkg::*; #(
  parameter int CELL_COUNT = TEXT_COLUMNS_DEF * TEXT_ROWS_DEF,
  parameter int CELL_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [CELL_W-1:0] rd_addr,
  output logic [15:0]       rd_data,
  input  logic              wr_en,
  input  logic [CELL_W-1:0] wr_addr,
  input  logic [15:0]       wr_data,
  output logic              clearing
);

  logic [15:0]       mem [CELL_COUNT];
  logic [CELL_W-1:0] clr_addr;

  // sweep every entry to its reset value after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == CELL_W'(CELL_COUNT - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (clearing) begin
      mem[clr_addr] <= {SHADOW_CHAR_RESET, SHADOW_ATTR_RESET};
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

### rtl/tccg_pixel_out.sv
`timescale 1ns / 1ps

module tccg_pixel_out import tccg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       row_valid,
  output logic       row_ready,
  input  logic [7:0] glyph,
  input  row_meta_t  meta,
  input  cfg_t       cfg,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [9:0] out_cell,
  output logic [2:0] pixel_row,
  output logic [3:0] pixel_0,
  output logic [3:0] pixel_1,
  output logic [3:0] pixel_2,
  output logic [3:0] pixel_3,
  output logic [3:0] pixel_4,
  output logic [3:0] pixel_5,
  output logic [3:0] pixel_6,
  output logic [3:0] pixel_7,
  output logic       last_row
);

  logic [3:0] pix [8];

  function automatic logic [3:0] shade(input logic on, input logic [7:0] attr, input cfg_t c);
    logic [3:0] v;
    if (c.color_mode) begin
      v = on ? attr[3:0] : attr[7:4];
    end else begin
      v = on ? COLOR_MAX : 4'd0;
    end
    if (c.negative_mode) begin
      v = COLOR_MAX - v;
    end
    return v;
  endfunction

  assign row_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (row_ready) begin
      out_valid <= row_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (row_ready && row_valid) begin
      out_cell  <= meta.cell_idx;
      pixel_row <= meta.row;
      last_row  <= (meta.row == ROW_LAST);
      for (int i = 0; i < 8; i++) begin
        // bit 7 is the leftmost pixel
        pix[i] <= shade(glyph[7 - i], meta.attr, cfg);
      end
    end
  end

  assign pixel_0 = pix[0];
  assign pixel_1 = pix[1];
  assign pixel_2 = pix[2];
  assign pixel_3 = pix[3];
  assign pixel_4 = pix[4];
  assign pixel_5 = pix[5];
  assign pixel_6 = pix[6];
  assign pixel_7 = pix[7];

endmodule

### tb/text_cell_character_generator_core_tb.sv
`timescale 1ns / 1ps

module text_cell_character_generator_core_tb;
  import tccg_pkg::*;

  localparam int CELLS          = TEXT_COLUMNS_DEF * TEXT_ROWS_DEF;
  localparam int RESET_CYCLES   = 5;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 5;
  localparam int PHASE_ITEMS    = 78;
  localparam int MAX_REPORTS    = 30;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [9:0] cell_idx;
    logic [7:0] code;
    logic [7:0] attr;
    logic [1:0] font;
    logic [2:0] frow;
    logic [7:0] fbyte;
  } req_t;

  typedef struct packed {
    req_t       req;
    logic [3:0] rows;
  } directed_t;

  typedef struct packed {
    logic [9:0]      cell_idx;
    logic [2:0]      row;
    logic [7:0][3:0] pix;
    logic            last;
  } glyph_row_t;

  localparam directed_t DIRECTED [19] = '{
    '{'{FUNC_FONT_WRITE, 10'h3FF, 8'h00, 8'hA5, 2'd0, 3'd0, 8'hFF}, 4'd0},
    '{'{FUNC_FONT_WRITE, 10'h000, 8'h00, 8'h5A, 2'd0, 3'd1, 8'h00}, 4'd0},
    '{'{FUNC_FONT_WRITE, 10'h155, 8'h00, 8'h00, 2'd0, 3'd2, 8'h80}, 4'd0},
    '{'{FUNC_FONT_WRITE, 10'h2AA, 8'h00, 8'hFF, 2'd0, 3'd3, 8'h01}, 4'd0},
    '{'{FUNC_FONT_WRITE, 10'h000, 8'h00, 8'h00, 2'd0, 3'd4, 8'hAA}, 4'd0},
    '{'{FUNC_FONT_WRITE, 10'h000, 8'h00, 8'h00, 2'd0, 3'd5, 8'h55}, 4'd0},
    '{'{FUNC_FONT_WRITE, 10'h000, 8'h00, 8'h00, 2'd0, 3'd6, 8'hF0}, 4'd0},
    '{'{FUNC_FONT_WRITE, 10'h000, 8'h00, 8'h00, 2'd0, 3'd7, 8'h0F}, 4'd0},
    // same as the cleared shadow: nothing to draw
    '{'{FUNC_CELL_CHECK, 10'd0,   8'h00, 8'h0F, 2'd3, 3'd7, 8'hFF}, 4'd0},
    '{'{FUNC_CELL_CHECK, 10'd767, 8'h00, 8'hF0, 2'd0, 3'd0, 8'h00}, 4'd8},
    '{'{FUNC_CELL_CHECK, 10'd767, 8'h00, 8'hF0, 2'd0, 3'd0, 8'h00}, 4'd0},
    // past the last cell of the screen
    '{'{FUNC_CELL_CHECK, 10'd768, 8'h00, 8'h5A, 2'd1, 3'd3, 8'h3C}, 4'd0},
    '{'{FUNC_CELL_CHECK, 10'h3FF, 8'h00, 8'hFF, 2'd2, 3'd4, 8'hC3}, 4'd0},
    '{'{FUNC_UNUSED,     10'h3FF, 8'hFF, 8'hFF, 2'd3, 3'd7, 8'hFF}, 4'd0},
    '{'{FUNC_FONT_WRITE, 10'd0,   8'hFF, 8'h00, 2'd3, 3'd7, 8'hFF}, 4'd0},
    '{'{FUNC_FRAME_END,  10'd5,   8'h12, 8'h34, 2'd1, 3'd2, 8'h56}, 4'd0},
    '{'{FUNC_CELL_CHECK, 10'd0,   8'h00, 8'hFF, 2'd0, 3'd0, 8'h00}, 4'd8},
    '{'{FUNC_CELL_CHECK, 10'd31,  8'h00, 8'h00, 2'd0, 3'd0, 8'h00}, 4'd8},
    '{'{FUNC_CELL_CHECK, 10'd32,  8'h00, 8'h0F, 2'd0, 3'd0, 8'h00}, 4'd0}
  };

  // color_mode, negative_mode, font_select
  localparam cfg_t PHASE_CFG [PHASES] = '{
    '{1'b0, 1'b0, 2'd0},
    '{1'b1, 1'b0, 2'd1},
    '{1'b1, 1'b1, 2'd3},
    '{1'b0, 1'b1, 2'd2},
    '{1'b1, 1'b1, 2'd0}
  };
  localparam int PHASE_SEND_IDLE [PHASES] = '{0, 50, 0, 23, 0};
  localparam int PHASE_RECV_STALL [PHASES] = '{0, 0, 50, 23, 0};

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [1:0] func       = '0;
  logic [9:0] cell_req   = '0;
  logic [7:0] char_code  = '0;
  logic [7:0] attribute  = '0;
  logic [1:0] font_index = '0;
  logic [2:0] font_row   = '0;
  logic [7:0] font_byte  = '0;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic [9:0] out_cell;
  logic [2:0] pixel_row;
  logic [3:0] pixel_0, pixel_1, pixel_2, pixel_3;
  logic [3:0] pixel_4, pixel_5, pixel_6, pixel_7;
  logic       last_row;
  logic       cfg_valid  = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index  = '0;
  logic [1:0] cfg_data   = '0;

  // predictor state
  logic [7:0]                    glyph_mem [FONT_COUNT_DEF * 2048];
  logic [FONT_COUNT_DEF*2048-1:0] glyph_set = '0;
  logic [FONT_COUNT_DEF*256-1:0]  code_listed = '0;
  logic [7:0]                    ready_codes [FONT_COUNT_DEF][$];
  logic [7:0]                    shadow_char [CELLS] = '{default: SHADOW_CHAR_RESET};
  logic [7:0]                    shadow_attr [CELLS] = '{default: SHADOW_ATTR_RESET};
  logic [1:0]                    drawn_font = '0;
  cfg_t                          cfg_now = '0;
  glyph_row_t                    glyph_rows_due [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int items_sent     = 0;
  int cells_redrawn  = 0;
  int rows_checked   = 0;
  int quiet_cycles   = 0;

  text_cell_character_generator_core u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Apply one accepted request to the shadow state and queue the glyph rows it draws.
  function automatic int render_request(input req_t r);
    int         n = 0;
    logic [7:0] bits;
    logic [3:0] c;
    glyph_row_t g;
    case (r.func)
      FUNC_FONT_WRITE: begin
        glyph_mem[{r.font, r.code, r.frow}] = r.fbyte;
        glyph_set[{r.font, r.code, r.frow}] = 1'b1;
        if (!code_listed[{r.font, r.code}] && (&glyph_set[{r.font, r.code, 3'd0} +: 8])) begin
          code_listed[{r.font, r.code}] = 1'b1;
          ready_codes[r.font].push_back(r.code);
        end
      end
      FUNC_CELL_CHECK: begin
        if (r.cell_idx < CELLS && (shadow_char[r.cell_idx] != r.code ||
            shadow_attr[r.cell_idx] != r.attr || drawn_font != cfg_now.font_select)) begin
          for (int row = 0; row < 8; row++) begin
            bits = glyph_mem[{cfg_now.font_select, r.code, 3'(row)}];
            g.cell_idx = r.cell_idx;
            g.row = 3'(row);
            g.last = (3'(row) == ROW_LAST);
            for (int k = 0; k < 8; k++) begin
              if (bits[7 - k]) c = cfg_now.color_mode ? r.attr[3:0] : COLOR_MAX;
              else c = cfg_now.color_mode ? r.attr[7:4] : 4'h0;
              if (cfg_now.negative_mode) c = COLOR_MAX - c;
              g.pix[k] = c;
            end
            glyph_rows_due.push_back(g);
          end
          shadow_char[r.cell_idx] = r.code;
          shadow_attr[r.cell_idx] = r.attr;
          cells_redrawn++;
          n = 8;
        end
      end
      FUNC_FRAME_END: drawn_font = cfg_now.font_select;
      default: ;
    endcase
    return n;
  endfunction

  function automatic req_t random_fields();
    req_t r;
    r.func     = 2'($urandom_range(0, 3));
    r.cell_idx = 10'($urandom_range(0, 1023));
    r.code     = 8'($urandom_range(0, 255));
    r.attr     = 8'($urandom_range(0, 255));
    r.font     = 2'($urandom_range(0, 3));
    r.frow     = 3'($urandom_range(0, 7));
    r.fbyte    = 8'($urandom_range(0, 255));
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic push_request(input req_t r, output int n);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    func       <= r.func;
    cell_req   <= r.cell_idx;
    char_code  <= r.code;
    attribute  <= r.attr;
    font_index <= r.font;
    font_row   <= r.frow;
    font_byte  <= r.fbyte;
    do @(posedge clk); while (in_stall);
    n = render_request(r);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic load_glyph(input logic [1:0] font, input logic [7:0] code);
    req_t r;
    int   n;
    for (int row = 0; row < 8; row++) begin
      r = random_fields();
      r.func = FUNC_FONT_WRITE;
      r.font = font;
      r.code = code;
      r.frow = 3'(row);
      push_request(r, n);
    end
  endtask

  task automatic send_random_item();
    req_t       r;
    int         pick;
    int         n;
    logic [1:0] f;
    r = random_fields();
    f = cfg_now.font_select;
    pick = $urandom_range(0, 99);
    if (pick < 55 && ready_codes[f].size() != 0) begin
      r.func = FUNC_CELL_CHECK;
      r.code = ready_codes[f][$urandom_range(0, ready_codes[f].size() - 1)];
      if (pick < 10) r.cell_idx = 10'($urandom_range(CELLS, 1023));
      else if (pick < 35) r.cell_idx = $urandom_range(0, 1) ? 10'($urandom_range(0, 7))
                                                             : 10'($urandom_range(CELLS - 8, CELLS - 1));
      else r.cell_idx = 10'($urandom_range(0, CELLS - 1));
      // repeat what the cell already shows, where its glyph is loaded in this font
      if (pick >= 10 && pick < 22 && code_listed[{f, shadow_char[r.cell_idx]}]) begin
        r.code = shadow_char[r.cell_idx];
        r.attr = shadow_attr[r.cell_idx];
      end
      push_request(r, n);
    end else if (pick < 70) begin
      load_glyph($urandom_range(0, 2) != 0 ? f : 2'($urandom_range(0, 3)),
                 8'($urandom_range(0, 255)));
    end else if (pick < 85) begin
      r.func = FUNC_FONT_WRITE;
      push_request(r, n);
    end else if (pick < 95) begin
      r.func = FUNC_FRAME_END;
      push_request(r, n);
    end else begin
      r.func = FUNC_UNUSED;
      push_request(r, n);
    end
  endtask

  // Drop valid and hold until every queued row has been seen, then settle.
  task automatic wait_idle(input int slack);
    in_valid <= 1'b0;
    do @(negedge clk); while (glyph_rows_due.size() != 0);
    repeat (slack) @(negedge clk);
  endtask

  task automatic write_settings(input cfg_t c);
    logic [1:0] idx [3];
    logic [1:0] val [3];
    idx = '{CFG_COLOR_MODE, CFG_NEGATIVE_MODE, CFG_FONT_SELECT};
    val = '{{1'b0, c.color_mode}, {1'b0, c.negative_mode}, c.font_select};
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    cfg_now = c;
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    glyph_row_t want;
    logic [3:0] seen [8];
    if (!rst && out_valid && !out_stall) begin
      seen = '{pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5, pixel_6, pixel_7};
      if (glyph_rows_due.size() == 0) begin
        report_mismatch($sformatf("unexpected row: cell %0d row %0d", out_cell, pixel_row));
      end else begin
        want = glyph_rows_due.pop_front();
        rows_checked++;
        if (out_cell !== want.cell_idx)
          report_mismatch($sformatf("out_cell got %0d want %0d", out_cell, want.cell_idx));
        if (pixel_row !== want.row)
          report_mismatch($sformatf("cell %0d: pixel_row got %0d want %0d",
                                    want.cell_idx, pixel_row, want.row));
        for (int k = 0; k < 8; k++) begin
          if (seen[k] !== want.pix[k])
            report_mismatch($sformatf("cell %0d row %0d: pixel_%0d got %0d want %0d",
                                      want.cell_idx, want.row, k, seen[k], want.pix[k]));
        end
        if (last_row !== want.last)
          report_mismatch($sformatf("cell %0d row %0d: last_row got %0b want %0b",
                                    want.cell_idx, want.row, last_row, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d rows still due",
               WATCHDOG_LIMIT, glyph_rows_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int n;
    int start;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 19; i++) begin
      push_request(DIRECTED[i].req, n);
      if (n != int'(DIRECTED[i].rows))
        report_mismatch($sformatf("directed step %0d: predicted %0d rows, table gives %0d",
                                  i, n, DIRECTED[i].rows));
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle(SETTLE_CYCLES);
      send_idle_pct  = PHASE_SEND_IDLE[p];
      recv_stall_pct = PHASE_RECV_STALL[p];
      write_settings(PHASE_CFG[p]);
      start = items_sent;
      repeat (2) load_glyph(cfg_now.font_select, 8'($urandom_range(0, 255)));
      while (items_sent - start < PHASE_ITEMS / 2) send_random_item();
      // hold off the sender until the output side has drained
      wait_idle(0);
      while (items_sent - start < PHASE_ITEMS) send_random_item();
    end

    wait_idle(END_CYCLES);
    $display("Ran %0d requests over %0d register settings with sender and receiver idling,",
             items_sent, PHASES);
    $display("  %0d cells redrawn and %0d glyph rows compared, %0d mismatches",
             cells_redrawn, rows_checked, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
rtl/tccg_pkg.sv
rtl/tccg_shadow_ram.sv
rtl/tccg_pixel_out.sv
rtl/text_cell_character_generator_core.sv
tb/text_cell_character_generator_core_tb.sv
